// ----- sv/byte_ring_buffer_with_search_core_macros.svh -----
// assertion helpers used by the datapath
`ifndef BYTE_RING_BUFFER_WITH_SEARCH_CORE_MACROS_SVH
`define BYTE_RING_BUFFER_WITH_SEARCH_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BRBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BRBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/brbs_pkg.sv -----
`timescale 1ns / 1ps

package brbs_pkg;

  localparam int DEPTH_DEF   = 4096;
  localparam int MAX_RUN_DEF = 64;

  localparam int CMD_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 13;
  localparam int OFFSET_W    = 12;
  localparam int LEVEL_W     = 13;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_SKIP  = 3'd2,
    CMD_FIND  = 3'd3,
    CMD_UNTIL = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_REQ,
    ST_SCAN_CMP,
    ST_SCAN_DONE,
    ST_RD_REQ,
    ST_RD_EMIT,
    ST_DROP,
    ST_SINGLE
  } state_t;

  // strobes from the controller, at most one of them per cycle
  typedef struct packed {
    logic load;
    logic setup;
    logic scan_rd;
    logic scan_cmp;
    logic until_setup;
    logic rd_req;
    logic emit;
    logic drop;
    logic single;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             lim_zero;
    logic             match;
    logic             scan_end;
    logic             rem_zero;
    logic             rem_one;
    logic             hit;
    logic             out_free;
  } dp_sts_t;

endpackage

// ----- sv/brbs_ctrl.sv -----
`timescale 1ns / 1ps

module brbs_ctrl import brbs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.setup = 1'b1;
        case (sts_i.cmd)
          CMD_READ:           state_nxt = sts_i.lim_zero ? ST_SINGLE : ST_RD_REQ;
          CMD_FIND, CMD_UNTIL: state_nxt = sts_i.lim_zero ? ST_SINGLE : ST_SCAN_REQ;
          default:            state_nxt = ST_SINGLE;
        endcase
      end
      ST_SCAN_REQ: begin
        cmd_o.scan_rd = 1'b1;
        state_nxt     = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_nxt      = (sts_i.match || sts_i.scan_end) ? ST_SCAN_DONE : ST_SCAN_REQ;
      end
      ST_SCAN_DONE: begin
        if (sts_i.cmd == CMD_UNTIL) begin
          cmd_o.until_setup = 1'b1;
          state_nxt         = sts_i.rem_zero ? ST_SINGLE : ST_RD_REQ;
        end else begin
          state_nxt = ST_SINGLE;
        end
      end
      ST_RD_REQ: begin
        cmd_o.rd_req = 1'b1;
        state_nxt    = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.rem_one) begin
            // the delimiter is consumed after the last byte before it
            state_nxt = (sts_i.cmd == CMD_UNTIL && sts_i.hit) ? ST_DROP : ST_IDLE;
          end else begin
            state_nxt = ST_RD_REQ;
          end
        end
      end
      ST_DROP: begin
        cmd_o.drop = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.single = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/brbs_datapath.sv -----
`timescale 1ns / 1ps
`include "byte_ring_buffer_with_search_core_macros.svh"

module brbs_datapath import brbs_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CMD_W-1:0]       item_cmd,
  input  logic [BYTE_W-1:0]      item_byte,
  input  logic [COUNT_W-1:0]     item_count,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int AW   = $clog2(DEPTH);
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int CMPW = (FW > COUNT_W) ? FW : COUNT_W;
  localparam int PAD  = OUT_TDATA_W - LEVEL_W - OFFSET_W - 2 - BYTE_W;

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0]   cmd_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [COUNT_W-1:0] count_r;
  logic [BYTE_W-1:0]  rd_data_r;

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt, scan_ptr_r, scan_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt, lim_r, lim_nxt, rem_r, rem_nxt;
  logic [FW-1:0] idx_r, idx_nxt, lvl_r, lvl_nxt, off_r, off_nxt;
  logic          hit_r, hit_nxt;

  logic                ov_r, ob_valid_r, oacc_r, ofound_r, olast_r;
  logic [BYTE_W-1:0]   obyte_r;
  logic [OFFSET_W-1:0] ooff_r;
  logic [LEVEL_W-1:0]  olvl_r;

  logic [CMPW-1:0] cnt_ext, fill_ext, run_ext, min_cf, min_run;
  logic [FW-1:0]   lim_dec, skip_n;
  logic [AW:0]     skip_sum;
  logic [AW-1:0]   skip_head, rd_addr;
  logic            full, match, wr_en, rd_en, out_free;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [LEVEL_W-1:0] to_level(input logic [FW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[LEVEL_W-1:0];
  endfunction

  function automatic logic [OFFSET_W-1:0] to_offset(input logic [FW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OFFSET_W-1:0];
  endfunction

  always_comb begin
    cnt_ext   = CMPW'(count_r);
    fill_ext  = CMPW'(fill_r);
    run_ext   = CMPW'(MAX_RUN);
    min_cf    = (cnt_ext < fill_ext) ? cnt_ext : fill_ext;
    min_run   = (min_cf < run_ext) ? min_cf : run_ext;
    lim_dec   = (cmd_r == CMD_FIND) ? fill_r : FW'(min_run);
    skip_n    = FW'(min_cf);
    // head plus at most DEPTH stays below twice DEPTH
    skip_sum  = (AW + 1)'(head_r) + (AW + 1)'(skip_n);
    skip_head = (skip_sum >= (AW + 1)'(DEPTH)) ? AW'(skip_sum - (AW + 1)'(DEPTH))
                                                : AW'(skip_sum);
    full      = (fill_r == FW'(DEPTH));
    match     = (rd_data_r == byte_r);
    wr_en     = cmd_i.single && (cmd_r == CMD_WRITE) && !full;
    rd_en     = cmd_i.scan_rd || cmd_i.rd_req;
    rd_addr   = cmd_i.scan_rd ? scan_ptr_r : head_r;
    out_free  = !ov_r || out_tready;
  end

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    lim_nxt      = lim_r;
    rem_nxt      = rem_r;
    idx_nxt      = idx_r;
    lvl_nxt      = lvl_r;
    off_nxt      = off_r;
    hit_nxt      = hit_r;
    scan_ptr_nxt = scan_ptr_r;
    if (cmd_i.setup) begin
      lim_nxt      = lim_dec;
      rem_nxt      = lim_dec;
      lvl_nxt      = fill_r - lim_dec;
      idx_nxt      = '0;
      scan_ptr_nxt = head_r;
      hit_nxt      = 1'b0;
      off_nxt      = '0;
    end
    if (cmd_i.scan_cmp) begin
      if (match) begin
        hit_nxt = 1'b1;
        off_nxt = idx_r;
        rem_nxt = idx_r;
      end else begin
        idx_nxt      = idx_r + FW'(1);
        rem_nxt      = idx_r + FW'(1);
        scan_ptr_nxt = ptr_inc(scan_ptr_r);
      end
    end
    if (cmd_i.until_setup) begin
      // bytes emitted plus the delimiter if one was met
      lvl_nxt = fill_r - rem_r - FW'(hit_r);
    end
    if (cmd_i.emit) begin
      head_nxt = ptr_inc(head_r);
      fill_nxt = fill_r - FW'(1);
      rem_nxt  = rem_r - FW'(1);
    end
    if (cmd_i.drop) begin
      head_nxt = ptr_inc(head_r);
      fill_nxt = fill_r - FW'(1);
    end
    if (cmd_i.single) begin
      case (cmd_r)
        CMD_WRITE: begin
          if (!full) begin
            tail_nxt = ptr_inc(tail_r);
            fill_nxt = fill_r + FW'(1);
          end
        end
        CMD_SKIP: begin
          head_nxt = skip_head;
          fill_nxt = fill_r - skip_n;
        end
        CMD_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          fill_nxt = '0;
        end
        CMD_UNTIL: begin
          // delimiter as the first byte: nothing emitted, delimiter consumed
          if (hit_r) begin
            head_nxt = ptr_inc(head_r);
            fill_nxt = fill_r - FW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r      <= lim_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    lvl_r      <= lvl_nxt;
    off_r      <= off_nxt;
    hit_r      <= hit_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    if (cmd_i.load) begin
      cmd_r   <= item_cmd;
      byte_r  <= item_byte;
      count_r <= item_count;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= byte_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd_i.single || cmd_i.emit) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.single) begin
      obyte_r    <= '0;
      ob_valid_r <= 1'b0;
      oacc_r     <= (cmd_r == CMD_WRITE) && !full;
      ofound_r   <= hit_r;
      ooff_r     <= to_offset(off_r);
      olvl_r     <= to_level(fill_nxt);
      olast_r    <= 1'b1;
    end else if (cmd_i.emit) begin
      obyte_r    <= rd_data_r;
      ob_valid_r <= 1'b1;
      oacc_r     <= 1'b0;
      ofound_r   <= hit_r;
      ooff_r     <= to_offset(off_r);
      olvl_r     <= to_level(lvl_r);
      olast_r    <= (rem_r == FW'(1));
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{PAD{1'b0}}, olvl_r, ooff_r, ofound_r, oacc_r, obyte_r};
  assign out_tuser  = ob_valid_r;
  assign out_tlast  = olast_r;

  assign sts_o.cmd      = cmd_r;
  assign sts_o.lim_zero = (lim_dec == '0);
  assign sts_o.match    = match;
  assign sts_o.scan_end = ((idx_r + FW'(1)) == lim_r);
  assign sts_o.rem_zero = (rem_r == '0);
  assign sts_o.rem_one  = (rem_r == FW'(1));
  assign sts_o.hit      = hit_r;
  assign sts_o.out_free = out_free;

  `BRBS_ASSERT_IMP(a_empty_ptrs, fill_r == '0, head_r == tail_r, "empty fifo with split pointers")
  `BRBS_ASSERT_IMP(a_pop_nonempty, cmd_i.emit || cmd_i.drop, fill_r != '0, "pop from empty fifo")
  `BRBS_ASSERT_IMP(a_out_slot, cmd_i.emit || cmd_i.single, !ov_r || out_tready, "result overwritten")
  `BRBS_ASSERT_NXT(a_hit_set, cmd_i.scan_cmp && match, hit_r, "scan match not recorded")

endmodule

// ----- sv/byte_ring_buffer_with_search_core.sv -----
`timescale 1ns / 1ps

// Circular byte fifo of DEPTH bytes with search, one command per input item
// (write, read run, skip, find, read until delimiter, clear), answering each
// item with one result, or with a run of up to MAX_RUN popped bytes whose last
// result carries tlast. Items are taken one at a time, only while the block is
// idle; results wait in an output register, so a stalled consumer only holds the
// block when a further result is due. The single-port byte store has a registered
// read, so each byte takes a request state and then a compare or emit state: write,
// skip, clear and unused commands go from decode straight to their one result; a read
// pops its bytes in turn; find compares bytes up to the match, examining at most the
// level, and then answers; read-until scans first and then pops. Every result
// carries the level after the whole item.
module byte_ring_buffer_with_search_core import brbs_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], count[20:8]
  input  logic [CMD_W-1:0]       in_tuser,   // command[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_byte[7:0], accepted[8], found[9],
                                             // offset[21:10], level[34:22]
  output logic                   out_tuser,  // byte_valid
  output logic                   out_tlast
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  brbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  brbs_datapath #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_cmd   (in_tuser),
    .item_byte  (in_tdata[BYTE_W-1:0]),
    .item_count (in_tdata[BYTE_W+COUNT_W-1:BYTE_W]),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import brbs_pkg::*;

  localparam int FIFO_DEPTH = DEPTH_DEF;
  localparam int RUN_MAX    = MAX_RUN_DEF;
  localparam int RANDOM_ITEMS = 86;
  localparam int HOLD_CYCLES  = 300;

  // command codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  typedef struct {
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                accepted;
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic [LEVEL_W-1:0]  level;
    logic                last;
  } fifo_result_t;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [BYTE_W-1:0]   data;
    logic [COUNT_W-1:0]  cnt;
    bit                  typed;
    logic                acc;
    logic                fnd;
    logic [OFFSET_W-1:0] off;
    logic [LEVEL_W-1:0]  lvl;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // data_byte[7:0], count[20:8]
  logic [CMD_W-1:0]       in_tuser;   // command[2:0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // out_byte[7:0], accepted[8], found[9],
                                      // offset[21:10], level[34:22]
  logic                   out_tuser;  // byte_valid
  logic                   out_tlast;

  // shadow copy of the fifo
  logic [BYTE_W-1:0] shadow_mem [FIFO_DEPTH];
  int                shadow_head;
  int                shadow_tail;
  int                shadow_level;

  fifo_result_t pending_results[$];
  fifo_result_t no_typed;
  dir_row_t     dir_rows[$];
  int           mismatch_count;
  bit           sender_gaps_on;
  bit           receiver_stalls_on;
  bit           hold_request;
  int           stall_left;

  byte_ring_buffer_with_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic fifo_result_t make_result(input logic [BYTE_W-1:0] b, input logic valid,
                                                input logic acc);
    fifo_result_t r;
    r.out_byte   = b;
    r.byte_valid = valid;
    r.accepted   = acc;
    r.found      = 1'b0;
    r.offset     = '0;
    r.level      = '0;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] shadow_pop();
    logic [BYTE_W-1:0] b;
    b = shadow_mem[shadow_head];
    shadow_head = (shadow_head + 1) % FIFO_DEPTH;
    shadow_level--;
    return b;
  endfunction

  function automatic int min_int(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // works out the results of one accepted item and queues them
  task automatic predict_fifo_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                                   input logic [COUNT_W-1:0] cnt, input bit use_typed,
                                   input fifo_result_t typed_res);
    fifo_result_t run[$];
    fifo_result_t r;
    logic [BYTE_W-1:0] b;
    logic acc;
    bit hit;
    int off;
    int lim;
    int i;
    int k;
    hit = 0;
    off = 0;
    acc = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        if (shadow_level < FIFO_DEPTH) begin
          shadow_mem[shadow_tail] = data;
          shadow_tail = (shadow_tail + 1) % FIFO_DEPTH;
          shadow_level++;
          acc = 1'b1;
        end
        run.push_back(make_result('0, 1'b0, acc));
      end
      CMD_READ: begin
        lim = min_int(min_int(int'(cnt), RUN_MAX), shadow_level);
        for (i = 0; i < lim; i++) run.push_back(make_result(shadow_pop(), 1'b1, 1'b0));
      end
      CMD_SKIP: begin
        lim = min_int(int'(cnt), shadow_level);
        shadow_head = (shadow_head + lim) % FIFO_DEPTH;
        shadow_level -= lim;
        run.push_back(make_result('0, 1'b0, 1'b0));
      end
      CMD_FIND: begin
        for (i = 0; i < shadow_level && !hit; i++) begin
          if (shadow_mem[(shadow_head + i) % FIFO_DEPTH] == data) begin
            hit = 1;
            off = i;
          end
        end
        run.push_back(make_result('0, 1'b0, 1'b0));
      end
      CMD_UNTIL: begin
        lim = min_int(int'(cnt), RUN_MAX);
        for (i = 0; i < lim && shadow_level > 0 && !hit; i++) begin
          b = shadow_pop();
          if (b == data) hit = 1;
          else run.push_back(make_result(b, 1'b1, 1'b0));
        end
        if (hit) off = run.size();
      end
      CMD_CLEAR: begin
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_level = 0;
        run.push_back(make_result('0, 1'b0, 1'b0));
      end
      default: begin
        run.push_back(make_result('0, 1'b0, 1'b0));
      end
    endcase
    // read and read-until answer with an empty result when nothing was popped
    if (run.size() == 0) run.push_back(make_result('0, 1'b0, 1'b0));
    if (use_typed) begin
      pending_results.push_back(typed_res);
    end else begin
      for (k = 0; k < run.size(); k++) begin
        r = run[k];
        r.found  = hit;
        r.offset = hit ? off[OFFSET_W-1:0] : '0;
        r.level  = shadow_level[LEVEL_W-1:0];
        r.last   = (k == run.size() - 1);
        pending_results.push_back(r);
      end
    end
  endtask

  function automatic int pick_idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 45);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return COUNT_W'($urandom_range(0, 70));
    if (r < 90) return COUNT_W'($urandom_range(0, 4096));
    return COUNT_W'($urandom_range(0, 8191));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    // a narrow alphabet half of the time so finds and delimiters hit
    if ($urandom_range(0, 1) == 0) return BYTE_W'($urandom_range(0, 7));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                           input logic [COUNT_W-1:0] cnt, input bit use_typed,
                           input fifo_result_t typed_res);
    int gap;
    gap = 0;
    if (sender_gaps_on && $urandom_range(0, 1) == 1) gap = pick_idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-COUNT_W-BYTE_W){1'b0}}, cnt, data};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    predict_fifo_item(cmd, data, cnt, use_typed, typed_res);
  endtask

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                      input logic [COUNT_W-1:0] cnt);
    send_item(cmd, data, cnt, 1'b0, no_typed);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                                  input logic [COUNT_W-1:0] cnt, input bit typed,
                                  input logic acc, input logic fnd,
                                  input logic [OFFSET_W-1:0] off,
                                  input logic [LEVEL_W-1:0] lvl);
    dir_row_t row;
    row.cmd   = cmd;
    row.data  = data;
    row.cnt   = cnt;
    row.typed = typed;
    row.acc   = acc;
    row.fnd   = fnd;
    row.off   = off;
    row.lvl   = lvl;
    dir_rows.push_back(row);
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    fifo_result_t exp_r;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got tdata 0x%0h", $time, out_tdata);
      mismatch_count++;
    end else begin
      exp_r = pending_results.pop_front();
      check_field("out_byte", exp_r.out_byte, out_tdata[7:0]);
      check_field("byte_valid", exp_r.byte_valid, out_tuser);
      check_field("accepted", exp_r.accepted, out_tdata[8]);
      check_field("found", exp_r.found, out_tdata[9]);
      check_field("offset", exp_r.offset, out_tdata[21:10]);
      check_field("level", exp_r.level, out_tdata[34:22]);
      check_field("last", exp_r.last, out_tlast);
      check_field("tdata padding", 0, out_tdata[OUT_TDATA_W-1:35]);
    end
  endtask

  // result side: checks every accepted item and throttles tready
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result();
      if (hold_request) begin
        stall_left   = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (receiver_stalls_on && $urandom_range(0, 4) == 0) begin
        stall_left = pick_idle_len() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    fifo_result_t typed_res;
    dir_row_t row;
    logic [CMD_W-1:0] cmd;
    logic [BYTE_W-1:0] delim;
    int r;
    int n;
    int i;
    int sent;

    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    in_tuser           = '0;
    mismatch_count     = 0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    hold_request       = 1'b0;
    shadow_head        = 0;
    shadow_tail        = 0;
    shadow_level       = 0;
    no_typed           = make_result('0, 1'b0, 1'b0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty fifo, extremes, delimiter cases, clear
    add_row(CMD_READ,     8'h00,    5, 1, 0, 0,    0, 0);
    add_row(CMD_UNTIL,    8'h00,   64, 1, 0, 0,    0, 0);
    add_row(CMD_FIND,     8'h00,    0, 1, 0, 0,    0, 0);
    add_row(CMD_SKIP,     8'h00, 8191, 1, 0, 0,    0, 0);
    add_row(CMD_UNUSED_6, 8'hFF, 8191, 1, 0, 0,    0, 0);
    add_row(CMD_UNUSED_7, 8'h00,    0, 1, 0, 0,    0, 0);
    add_row(CMD_WRITE,    8'h00,    0, 1, 1, 0,    0, 1);
    add_row(CMD_WRITE,    8'hFF, 8191, 1, 1, 0,    0, 2);
    add_row(CMD_WRITE,    8'hA5,    0, 0, 0, 0,    0, 0);
    add_row(CMD_WRITE,    8'h5A,    0, 0, 0, 0,    0, 0);
    add_row(CMD_WRITE,    8'h3C,    0, 0, 0, 0,    0, 0);
    add_row(CMD_WRITE,    8'h0F,    0, 0, 0, 0,    0, 0);
    add_row(CMD_FIND,     8'hFF,    0, 1, 0, 1,    1, 6);
    add_row(CMD_FIND,     8'h77,    0, 1, 0, 0,    0, 6);
    add_row(CMD_READ,     8'h00,    0, 1, 0, 0,    0, 6);
    add_row(CMD_SKIP,     8'h00,    0, 1, 0, 0,    0, 6);
    add_row(CMD_UNTIL,    8'h3C,    0, 1, 0, 0,    0, 6);
    add_row(CMD_READ,     8'h00,    1, 0, 0, 0,    0, 0);
    add_row(CMD_UNTIL,    8'hA5,   64, 0, 0, 0,    0, 0);
    add_row(CMD_UNTIL,    8'h99,    1, 0, 0, 0,    0, 0);
    add_row(CMD_UNTIL,    8'h3C,   64, 0, 0, 0,    0, 0);  // delimiter at the head
    add_row(CMD_UNTIL,    8'h11,   64, 0, 0, 0,    0, 0);  // runs empty
    add_row(CMD_WRITE,    8'h81,    0, 0, 0, 0,    0, 0);
    add_row(CMD_CLEAR,    8'h00,    0, 1, 0, 0,    0, 0);
    add_row(CMD_READ,     8'h00, 4096, 1, 0, 0,    0, 0);

    for (i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      typed_res          = make_result('0, 1'b0, row.acc);
      typed_res.found    = row.fnd;
      typed_res.offset   = row.off;
      typed_res.level    = row.lvl;
      typed_res.last     = 1'b1;
      send_item(row.cmd, row.data, row.cnt, row.typed, typed_res);
    end
    wait_drained();

    // back-to-back writes with no idling, search them, then a capped read run
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    for (i = 0; i < 65; i++) send(CMD_WRITE, BYTE_W'($urandom_range(0, 253)), 0);
    send(CMD_WRITE, 8'hFE, 0);
    send(CMD_FIND, 8'hFE, 0);
    send(CMD_FIND, 8'hFF, 0);
    send(CMD_READ, 8'h00, 4096);
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    send(CMD_SKIP, 8'h00, 4000);
    send(CMD_READ, 8'h00, 100);
    for (i = 0; i < 16; i++) send(CMD_WRITE, pick_byte(), 0);
    wait_drained();

    // consumer holds off while items keep coming, so the block backs up
    hold_request = 1'b1;
    sender_gaps_on = 1'b0;
    for (i = 0; i < 8; i++) send(CMD_READ, 8'h00, 1);
    send(CMD_FIND, 8'h03, 0);
    for (i = 0; i < 3; i++) send(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), 0);
    sender_gaps_on = 1'b1;

    // random part, mostly framed messages and mixed commands
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sender_gaps_on     = (sent % 60) < 45;
      receiver_stalls_on = ((sent + 30) % 60) < 45;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send(CMD_WRITE, pick_byte(), 0);
        sent++;
      end else if (r < 50) begin
        send(CMD_READ, pick_byte(), pick_count());
        sent++;
      end else if (r < 60) begin
        send(CMD_UNTIL, pick_byte(), pick_count());
        sent++;
      end else if (r < 70) begin
        send(CMD_FIND, pick_byte(), pick_count());
        sent++;
      end else if (r < 76) begin
        send(CMD_SKIP, pick_byte(), ($urandom_range(0, 7) == 0) ? pick_count()
                                    : COUNT_W'($urandom_range(0, 12)));
        sent++;
      end else if (r < 94) begin
        // a message of plain bytes closed by a delimiter, then read up to it
        delim = pick_byte();
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) send(CMD_WRITE, delim ^ BYTE_W'($urandom_range(1, 255)), 0);
        send(CMD_WRITE, delim, 0);
        if ($urandom_range(0, 3) == 0) send(CMD_FIND, delim, 0);
        send(CMD_UNTIL, delim, ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 8))
                                                           : COUNT_W'(64));
        sent += n + 2;
      end else if (r < 97) begin
        send(CMD_CLEAR, pick_byte(), pick_count());
        sent++;
      end else begin
        cmd = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        send(cmd, pick_byte(), pick_count());
        sent++;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/brbs_pkg.sv
sv/brbs_ctrl.sv
sv/brbs_datapath.sv
sv/byte_ring_buffer_with_search_core.sv
tb/tb.sv
